// ===== sv/mrsp_pkg.sv =====
package mrsp_pkg;

  // Varint value width; bits above it are dropped while a varint is collected.
  localparam int VALUE_BITS = 32;
  // Width of references, line numbers and the string count.
  localparam int REF_W = 32;
  // Number of varint bytes that can still contribute data bits.
  localparam int VARINT_BYTES = (VALUE_BITS + 6) / 7;
  localparam int IDX_W = $clog2(VARINT_BYTES + 1);
  localparam int SHAMT_W = $clog2(VARINT_BYTES * 7 + 1);

  localparam int KIND_W = 4;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register index of the format mode register.
  localparam logic REG_COMPAT = 1'b0;

  // Record type bytes.
  localparam logic [7:0] RT_STRING    = 8'd1;
  localparam logic [7:0] RT_FUNCTION  = 8'd2;
  localparam logic [7:0] RT_BLOCK     = 8'd3;
  localparam logic [7:0] RT_INSTR     = 8'd4;
  localparam logic [7:0] RT_LINE      = 8'd5;
  localparam logic [7:0] RT_CANDIDATE = 8'd6;
  localparam logic [7:0] RT_INJECTED  = 8'd7;
  localparam logic [7:0] RT_MODULE    = 8'd8;

  // Event codes.
  localparam logic [KIND_W-1:0] EV_FUNCTION  = 4'd0;
  localparam logic [KIND_W-1:0] EV_BLOCK     = 4'd1;
  localparam logic [KIND_W-1:0] EV_INSTR     = 4'd2;
  localparam logic [KIND_W-1:0] EV_LINE      = 4'd3;
  localparam logic [KIND_W-1:0] EV_CANDIDATE = 4'd4;
  localparam logic [KIND_W-1:0] EV_INJECTED  = 4'd5;
  localparam logic [KIND_W-1:0] EV_MODULE    = 4'd6;
  localparam logic [KIND_W-1:0] EV_DONE      = 4'd7;
  localparam logic [KIND_W-1:0] EV_BAD_TYPE  = 4'd8;
  localparam logic [KIND_W-1:0] EV_BAD_REF   = 4'd9;
  localparam logic [KIND_W-1:0] EV_TRUNCATED = 4'd10;

  // Control from the parser to the varint collector.
  typedef struct packed {
    logic take;
    logic clear;
  } varint_ctl_t;

  // Status from the varint collector: value including the current byte.
  typedef struct packed {
    logic             last;
    logic [REF_W-1:0] value;
  } varint_sts_t;

  // One event produced by the parser for the current byte.
  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [REF_W-1:0]  first_ref;
    logic [REF_W-1:0]  second_value;
    logic              second_valid;
  } event_t;

endpackage

// ===== sv/mrsp_cfg_regs.sv =====
module mrsp_cfg_regs
  import mrsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic              compat_mode
);

  logic compat_r;
  logic compat_nxt;
  logic reg_hit;

  // Register index sits above the byte offset.
  assign reg_hit = (paddr[APB_AW-1] == REG_COMPAT);
  assign pready  = 1'b1;

  // A write lands in the access phase of a write request.
  always_comb begin
    compat_nxt = compat_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      compat_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compat_r <= 1'b0;
    end else begin
      compat_r <= compat_nxt;
    end
  end

  assign prdata      = reg_hit ? {{(APB_DW-1){1'b0}}, compat_r} : '0;
  assign compat_mode = compat_r;

endmodule

// ===== sv/mrsp_varint.sv =====
module mrsp_varint
  import mrsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  varint_ctl_t ctl,
  input  logic [7:0]  data_byte,
  output varint_sts_t sts
);

  logic [VALUE_BITS-1:0] accum_r;
  logic [VALUE_BITS-1:0] accum_nxt;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      idx_nxt;
  logic [SHAMT_W-1:0]    shamt;
  logic [VALUE_BITS-1:0] merged;

  // Seven data bits per byte, placed at the byte's position while it still fits.
  assign shamt = SHAMT_W'(idx_r) * SHAMT_W'(7);

  always_comb begin
    merged = accum_r;
    if (idx_r < IDX_W'(VARINT_BYTES)) begin
      merged = accum_r | (VALUE_BITS'(data_byte[6:0]) << shamt);
    end
  end

  assign sts.last  = ~data_byte[7];
  assign sts.value = REF_W'(merged);

  // Completion or an explicit clear starts the next varint afresh.
  always_comb begin
    accum_nxt = accum_r;
    idx_nxt   = idx_r;
    if (ctl.clear) begin
      accum_nxt = '0;
      idx_nxt   = '0;
    end else if (ctl.take) begin
      if (sts.last) begin
        accum_nxt = '0;
        idx_nxt   = '0;
      end else begin
        accum_nxt = merged;
        if (idx_r < IDX_W'(VARINT_BYTES)) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      idx_r   <= '0;
    end else begin
      accum_r <= accum_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== sv/mrsp_parser.sv =====
module mrsp_parser
  import mrsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  input  logic        compat_mode,
  input  varint_sts_t vsts,
  output varint_ctl_t vctl,
  output event_t      ev
);

  localparam logic [1:0] PH_TYPE   = 2'd0;
  localparam logic [1:0] PH_STRING = 2'd1;
  localparam logic [1:0] PH_FIELD1 = 2'd2;
  localparam logic [1:0] PH_FIELD2 = 2'd3;

  logic [1:0]       phase_r,  phase_nxt;
  logic [3:0]       rtype_r,  rtype_nxt;
  logic [REF_W-1:0] held_r,   held_nxt;
  logic [REF_W-1:0] count_r,  count_nxt;
  logic             halted_r, halted_nxt;
  logic             ref_bad;

  assign ref_bad = (vsts.value >= count_r);

  // Per-byte decode: next parse state and at most one event.
  always_comb begin
    phase_nxt  = phase_r;
    rtype_nxt  = rtype_r;
    held_nxt   = held_r;
    count_nxt  = count_r;
    halted_nxt = halted_r;
    vctl       = '0;
    ev         = '0;
    if (fire && !halted_r) begin
      if (end_of_file) begin
        halted_nxt = 1'b1;
        ev.valid   = 1'b1;
        ev.kind    = (phase_r == PH_TYPE) ? EV_DONE : EV_TRUNCATED;
        phase_nxt  = PH_TYPE;
      end else begin
        case (phase_r)
          PH_TYPE: begin
            vctl.clear = 1'b1;
            if (data_byte == RT_STRING) begin
              rtype_nxt = data_byte[3:0];
              phase_nxt = PH_STRING;
            end else if (data_byte == RT_BLOCK) begin
              ev.valid = 1'b1;
              ev.kind  = EV_BLOCK;
            end else if (data_byte == RT_INSTR) begin
              ev.valid = 1'b1;
              ev.kind  = EV_INSTR;
            end else if (data_byte == RT_FUNCTION || data_byte == RT_LINE ||
                         data_byte == RT_CANDIDATE || data_byte == RT_INJECTED ||
                         data_byte == RT_MODULE) begin
              rtype_nxt = data_byte[3:0];
              phase_nxt = PH_FIELD1;
            end else begin
              halted_nxt = 1'b1;
              ev.valid   = 1'b1;
              ev.kind    = EV_BAD_TYPE;
            end
          end
          PH_STRING: begin
            if (data_byte == 8'd0) begin
              if (count_r != {REF_W{1'b1}}) begin
                count_nxt = count_r + REF_W'(1);
              end
              phase_nxt = PH_TYPE;
            end
          end
          PH_FIELD1: begin
            vctl.take = 1'b1;
            if (vsts.last) begin
              if (ref_bad) begin
                halted_nxt   = 1'b1;
                phase_nxt    = PH_TYPE;
                ev.valid     = 1'b1;
                ev.kind      = EV_BAD_REF;
                ev.first_ref = vsts.value;
              end else if (rtype_r == RT_FUNCTION[3:0] || rtype_r == RT_LINE[3:0]) begin
                held_nxt  = vsts.value;
                phase_nxt = PH_FIELD2;
              end else begin
                phase_nxt    = PH_TYPE;
                ev.valid     = 1'b1;
                ev.first_ref = vsts.value;
                if (rtype_r == RT_CANDIDATE[3:0]) begin
                  ev.kind = EV_CANDIDATE;
                end else if (rtype_r == RT_INJECTED[3:0]) begin
                  ev.kind = EV_INJECTED;
                end else begin
                  ev.kind = EV_MODULE;
                end
              end
            end
          end
          default: begin
            vctl.take = 1'b1;
            if (vsts.last) begin
              phase_nxt = PH_TYPE;
              ev.valid  = 1'b1;
              if (rtype_r == RT_LINE[3:0]) begin
                ev.kind         = EV_LINE;
                ev.first_ref    = held_r;
                ev.second_value = vsts.value;
                ev.second_valid = 1'b1;
              end else if (compat_mode) begin
                ev.kind      = EV_FUNCTION;
                ev.first_ref = held_r;
              end else if (ref_bad) begin
                halted_nxt   = 1'b1;
                ev.kind      = EV_BAD_REF;
                ev.first_ref = vsts.value;
              end else begin
                ev.kind         = EV_FUNCTION;
                ev.first_ref    = held_r;
                ev.second_value = vsts.value;
                ev.second_valid = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      rtype_r  <= '0;
      held_r   <= '0;
      count_r  <= '0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      rtype_r  <= rtype_nxt;
      held_r   <= held_nxt;
      count_r  <= count_nxt;
      halted_r <= halted_nxt;
    end
  end

  // Done and every error event stop the parser.
  a_stop_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    ev.valid && (ev.kind == EV_DONE || ev.kind == EV_BAD_TYPE ||
                 ev.kind == EV_BAD_REF || ev.kind == EV_TRUNCATED) |=> halted_r)
    else $error("parser did not halt after a final event");

  // A halted parser produces nothing.
  a_quiet_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !ev.valid && !vctl.take)
    else $error("event produced while halted");

  // The string count never goes down.
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r >= $past(count_r))
    else $error("string count decreased");

  // Only function and line info records have a second field.
  a_field2_type: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FIELD2 |-> rtype_r == RT_FUNCTION[3:0] || rtype_r == RT_LINE[3:0])
    else $error("second field phase with wrong record type");

endmodule

// ===== sv/map_record_stream_parser.sv =====
// Map record stream parser.
// The input channel (in_valid/in_ready) carries one byte of a binary map file
// per request, or an end-of-file mark when in_end_of_file is high. The output
// channel (out_valid/out_ready) carries one event per completed record other
// than a string record, done at a clean end of file, or an error event, after
// which the block halts and silently consumes further requests until reset.
// Throughput is one byte per cycle unless the receiver stalls. A request
// passes an input register, is decoded against the parse state once the output
// register has room, and lands in the output register, from which its event is
// offered. The byte rate is set by the parse state update, which must settle
// before the next byte is decoded.
// When the receiver stalls, the output register holds its event and the input
// register holds one more byte; in_ready then drops until the event is taken.
// Synchronous reset empties both registers, returns the parser to waiting for
// a record type byte, clears the string count and selects the latest format.
// The compat_mode register (byte address 0 of the APB port) may only be
// written while no request is in flight.
module map_record_stream_parser
  import mrsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_file,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_event_kind,
  output logic [REF_W-1:0]  out_first_ref,
  output logic [REF_W-1:0]  out_second_value,
  output logic              out_second_valid,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_eof_r;
  logic        fire;
  logic        compat_mode;
  varint_ctl_t vctl;
  varint_sts_t vsts;
  event_t      ev;
  event_t      out_r;
  logic        out_valid_r;

  // Decode the held byte once the output register has room.
  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
      in_eof_r  <= in_end_of_file;
    end
  end

  mrsp_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .compat_mode (compat_mode)
  );

  mrsp_varint u_varint (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (vctl),
    .data_byte (in_byte_r),
    .sts       (vsts)
  );

  mrsp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data_byte   (in_byte_r),
    .end_of_file (in_eof_r),
    .compat_mode (compat_mode),
    .vsts        (vsts),
    .vctl        (vctl),
    .ev          (ev)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= ev.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ev.valid) begin
      out_r <= ev;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_r.kind;
  assign out_first_ref    = out_r.first_ref;
  assign out_second_value = out_r.second_value;
  assign out_second_valid = out_r.second_valid;

endmodule
